// ----- hw/rtl/bsd_pkg.sv -----
// Package for the Brusselator stencil derivative block.
// Holds the number format, payload and queue types, state codes and the
// saturating fixed-point helpers. Depends on nothing.
`default_nettype none

package bsd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 20;
    localparam int ADDR_W     = 4;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    typedef logic signed [DATA_WIDTH-1:0]   t_word;
    typedef logic signed [2*DATA_WIDTH-1:0] t_prod;

    localparam t_word FX_ONE = {{(DATA_WIDTH-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam t_word FX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_word FX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam t_word CFG_FEED_RST  = FX_ONE;
    localparam t_word CFG_REACT_RST = t_word'(3 * (longint'(1) << FRAC_BITS));
    localparam t_word CFG_DIFF_RST  = t_word'((2 * (longint'(1) << FRAC_BITS) + 50) / 100);

    typedef enum logic [1:0] {
        REG_FEED,
        REG_REACT,
        REG_DIFF
    } t_reg_idx;

    typedef struct packed {
        t_word u_value;
        t_word v_value;
        logic  last_node;
    } t_in_item;

    typedef struct packed {
        t_word du_value;
        t_word dv_value;
        logic  is_boundary;
        logic  last_result;
    } t_out_item;

    typedef struct packed {
        t_word feed_rate;
        t_word reaction_rate;
        t_word diffusion_gain;
    } t_coeffs;

    typedef enum logic [1:0] {
        TK_NONE,
        TK_BOUND,
        TK_INTERIOR
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  last;
        t_word u_left;
        t_word u_mid;
        t_word u_right;
        t_word v_left;
        t_word v_mid;
        t_word v_right;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_C1,
        BS_C2,
        BS_C3,
        BS_C4,
        BS_C5,
        BS_C6,
        BS_C7,
        BS_C8,
        BS_C9,
        BS_PUT,
        BS_LAST
    } t_bstate;

    function automatic t_word fx_add(input t_word a, input t_word b);
        logic [DATA_WIDTH:0] s;
        t_word r;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            r = s[DATA_WIDTH] ? FX_MIN : FX_MAX;
        end else begin
            r = s[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic t_word fx_sub(input t_word a, input t_word b);
        logic [DATA_WIDTH:0] s;
        t_word r;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            r = s[DATA_WIDTH] ? FX_MIN : FX_MAX;
        end else begin
            r = s[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // Floor-rounded rescale of an exact product, then saturation.
    function automatic t_word fx_scale(input t_prod p);
        t_prod q;
        logic [DATA_WIDTH:0] hi;
        t_word r;
        q  = p >>> FRAC_BITS;
        hi = q[2*DATA_WIDTH-1:DATA_WIDTH-1];
        if ((&hi) || !(|hi)) begin
            r = q[DATA_WIDTH-1:0];
        end else if (q[2*DATA_WIDTH-1]) begin
            r = FX_MIN;
        end else begin
            r = FX_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bsd_front.sv -----
// Front end: accepts grid nodes, keeps the two-node window and turns each
// node into a task for the back end. Depends on bsd_pkg.
`default_nettype none

module bsd_front
    import bsd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    input  wire t_qstat   i_qstat,
    output logic          o_push,
    output t_task         o_push_data
);

    logic [1:0] r_seen;
    logic [1:0] n_seen;
    t_word      r_u0;
    t_word      r_u1;
    t_word      r_v0;
    t_word      r_v1;
    logic       w_accept;

    assign o_in_ready = !i_qstat.full;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_push_data.last    = i_in_data.last_node;
        o_push_data.u_left  = r_u1;
        o_push_data.u_mid   = r_u0;
        o_push_data.u_right = i_in_data.u_value;
        o_push_data.v_left  = r_v1;
        o_push_data.v_mid   = r_v0;
        o_push_data.v_right = i_in_data.v_value;
        if (r_seen == 2'd2) begin
            o_push_data.kind = TK_INTERIOR;
        end else if (r_seen == 2'd1) begin
            o_push_data.kind = TK_BOUND;
        end else begin
            o_push_data.kind = TK_NONE;
        end
    end

    assign o_push = w_accept && ((r_seen != 2'd0) || i_in_data.last_node);

    always_comb begin
        n_seen = r_seen;
        if (w_accept) begin
            if (i_in_data.last_node) begin
                n_seen = 2'd0;
            end else if (r_seen != 2'd2) begin
                n_seen = r_seen + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 2'd0;
        end else begin
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u1 <= '0;
            r_v1 <= '0;
            r_u0 <= '0;
            r_v0 <= '0;
        end else if (w_accept) begin
            r_u1 <= r_u0;
            r_v1 <= r_v0;
            r_u0 <= i_in_data.u_value;
            r_v0 <= i_in_data.v_value;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bsd_queue.sv -----
// Short task queue between the front and back ends.
// Depends on bsd_pkg.
`default_nettype none

module bsd_queue
    import bsd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_task i_push_data,
    input  wire logic  i_pop,
    output t_task      o_head,
    output t_qstat     o_stat
);

    t_task           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_count;
    logic [Q_AW-1:0] n_wr;
    logic [Q_AW-1:0] n_rd;
    logic [Q_AW:0]   n_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + Q_AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + Q_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (Q_AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bsd_back.sv -----
// Back end: evaluates each task on one shared multiplier and saturating
// adders, then drives the output register. Depends on bsd_pkg.
`default_nettype none

module bsd_back
    import bsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_coeffs i_coef,
    input  wire t_qstat  i_qstat,
    input  wire t_task   i_head,
    output logic         o_pop,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_out_item    o_out_data
);

    t_bstate   r_state;
    t_bstate   n_state;
    t_task     r_task;
    logic      r_out_valid;
    t_out_item r_out;
    logic      w_free;
    logic      w_load;
    t_out_item w_out;
    t_word     w_mul_a;
    t_word     w_mul_b;
    t_prod     w_prod;

    t_prod r_prod;
    t_word r_m;
    t_word r_bp1;
    t_word r_su;
    t_word r_tu;
    t_word r_sv;
    t_word r_tv;
    t_word r_uu;
    t_word r_t;
    t_word r_bu;
    t_word r_uuv;
    t_word r_lu;
    t_word r_du;
    t_word r_dv;

    assign w_free      = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (!i_qstat.empty) begin
                    case (i_head.kind)
                        TK_INTERIOR: n_state = BS_C1;
                        TK_BOUND:    n_state = BS_PUT;
                        default:     n_state = BS_LAST;
                    endcase
                end
            end
            BS_C1: n_state = BS_C2;
            BS_C2: n_state = BS_C3;
            BS_C3: n_state = BS_C4;
            BS_C4: n_state = BS_C5;
            BS_C5: n_state = BS_C6;
            BS_C6: n_state = BS_C7;
            BS_C7: n_state = BS_C8;
            BS_C8: n_state = BS_C9;
            BS_C9: n_state = BS_PUT;
            BS_PUT: begin
                if (w_free) begin
                    n_state = r_task.last ? BS_LAST : BS_IDLE;
                end
            end
            BS_LAST: begin
                if (w_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        w_load  = 1'b0;
        w_out   = '{du_value: '0, dv_value: '0, is_boundary: 1'b1, last_result: 1'b0};
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            BS_IDLE: o_pop = !i_qstat.empty;
            BS_C1: begin
                w_mul_a = r_task.u_mid;
                w_mul_b = r_task.u_mid;
            end
            BS_C2: begin
                w_mul_a = r_bp1;
                w_mul_b = r_task.u_mid;
            end
            BS_C3: begin
                w_mul_a = i_coef.reaction_rate;
                w_mul_b = r_task.u_mid;
            end
            BS_C4: begin
                w_mul_a = r_uu;
                w_mul_b = r_task.v_mid;
            end
            BS_C5: begin
                w_mul_a = i_coef.diffusion_gain;
                w_mul_b = r_su;
            end
            BS_C6: begin
                w_mul_a = i_coef.diffusion_gain;
                w_mul_b = r_sv;
            end
            BS_PUT: begin
                w_load = w_free;
                if (r_task.kind == TK_INTERIOR) begin
                    w_out.du_value    = r_du;
                    w_out.dv_value    = r_dv;
                    w_out.is_boundary = 1'b0;
                end
            end
            BS_LAST: begin
                w_load            = w_free;
                w_out.last_result = 1'b1;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_m    <= fx_scale(r_prod);
        if (o_pop) begin
            r_task <= i_head;
        end
        if (w_load) begin
            r_out <= w_out;
        end
        case (r_state)
            BS_C1: begin
                r_bp1 <= fx_add(i_coef.reaction_rate, FX_ONE);
                r_su  <= fx_add(r_task.u_left, r_task.u_right);
                r_tu  <= fx_add(r_task.u_mid, r_task.u_mid);
                r_sv  <= fx_add(r_task.v_left, r_task.v_right);
                r_tv  <= fx_add(r_task.v_mid, r_task.v_mid);
            end
            BS_C2: begin
                r_su <= fx_sub(r_su, r_tu);
                r_sv <= fx_sub(r_sv, r_tv);
            end
            BS_C3: r_uu  <= r_m;
            BS_C4: r_t   <= r_m;
            BS_C5: r_bu  <= r_m;
            BS_C6: r_uuv <= r_m;
            BS_C7: begin
                r_du <= fx_add(i_coef.feed_rate, r_uuv);
                r_dv <= fx_sub(r_bu, r_uuv);
                r_lu <= r_m;
            end
            BS_C8: begin
                r_du <= fx_sub(r_du, r_t);
                r_dv <= fx_add(r_dv, r_m);
            end
            BS_C9: r_du <= fx_add(r_du, r_lu);
            default: begin
                r_lu <= r_lu;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/brusselator_stencil_derivative.sv -----
// Brusselator 1-D reaction-diffusion right-hand side over a stream of nodes.
// An interior result is registered after its task leaves the queue and runs
// through states BS_C1 to BS_C9 and BS_PUT, which waits while the output is held;
// an end-node result is registered in BS_PUT. The back end takes no new task
// until the last is put out; a task that also closes the grid adds BS_LAST.
// Reset clears the window, queue and output register and loads the defaults.
`default_nettype none

module brusselator_stencil_derivative
    import bsd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_coeffs r_coef;
    t_qstat  w_qstat;
    t_task   w_head;
    t_task   w_push_data;
    logic    w_push;
    logic    w_pop;
    logic    w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.feed_rate      <= CFG_FEED_RST;
            r_coef.reaction_rate  <= CFG_REACT_RST;
            r_coef.diffusion_gain <= CFG_DIFF_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_FEED:  r_coef.feed_rate      <= pwdata;
                REG_REACT: r_coef.reaction_rate  <= pwdata;
                REG_DIFF:  r_coef.diffusion_gain <= pwdata;
                default:   r_coef                <= r_coef;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FEED:  prdata = r_coef.feed_rate;
            REG_REACT: prdata = r_coef.reaction_rate;
            REG_DIFF:  prdata = r_coef.diffusion_gain;
            default:   prdata = '0;
        endcase
    end

    bsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    bsd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_qstat)
    );

    bsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coef      (r_coef),
        .i_qstat     (w_qstat),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("task popped from an empty queue");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("task pushed into a full queue");

    a_boundary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_boundary) |->
            (o_out_data.du_value == '0 && o_out_data.dv_value == '0))
        else $error("boundary result carries nonzero derivatives");

    a_last_is_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_result) |-> o_out_data.is_boundary)
        else $error("final result is not marked as boundary");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
